// ===== src/icmb_pkg.sv =====
// ----------------------------------------------------------------------------
// icmb_pkg
// Shared constants and types for the ICMP message builder: sizes, IPv4 quote
// limits and the message descriptor passed from the front to the back part.
// ----------------------------------------------------------------------------
package icmb_pkg;

  localparam int MAX_PAYLOAD_DEF = 248;
  localparam int CNT_W           = 8;
  localparam int POS_W           = 9;
  localparam int SUM_W           = 16 + CNT_W;
  localparam int ACC_W           = SUM_W + 1;
  localparam int HDR_BYTES       = 8;
  localparam int QUOTE_EXTRA     = 8;
  localparam int MIN_QUOTE_BYTES = 20;
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL      = 4'd5;

  typedef struct packed {
    logic [7:0]       msg_type;
    logic [7:0]       msg_code;
    logic [15:0]      csum;
    logic [15:0]      rest_high;
    logic [15:0]      rest_low;
    logic [CNT_W-1:0] qlen;
    logic             trunc;
  } msg_desc_t;

  typedef struct packed {
    logic      valid;
    msg_desc_t desc;
  } desc_chan_t;

endpackage

// ===== src/icmb_ram.sv =====
// ----------------------------------------------------------------------------
// icmb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module icmb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 248,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/icmb_front.sv =====
// ----------------------------------------------------------------------------
// icmb_front
// Accepts items, captures the header and mode, writes payload bytes into the
// byte store and keeps running checksums over the whole payload and over the
// IPv4 quote. After the last item it resolves the quote length and checksum
// and queues one message descriptor for the back part.
// ----------------------------------------------------------------------------
module icmb_front #(
  parameter int MAX_PAYLOAD = icmb_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDR_W      = $clog2(MAX_PAYLOAD)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [7:0]              in_msg_type,
  input  logic [7:0]              in_msg_code,
  input  logic [15:0]             in_rest_high,
  input  logic [15:0]             in_rest_low,
  input  logic                    in_error_mode,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_byte_present,
  input  logic                    in_last_byte,
  input  logic                    back_idle,
  input  logic                    desc_pop,
  output icmb_pkg::desc_chan_t    desc_chan,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output logic [7:0]              ram_wdata
);

  import icmb_pkg::*;

  typedef enum logic {F_LOAD, F_FINISH} fstate_t;

  fstate_t          fstate_r, fstate_nxt;
  logic             in_msg_r, in_msg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [15:0]      rh_r, rh_nxt;
  logic [15:0]      rl_r, rl_nxt;
  logic             mode_r, mode_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       byte0_r, byte0_nxt;
  logic [SUM_W-1:0] fsum_r, fsum_nxt;
  logic [SUM_W-1:0] qsum_r, qsum_nxt;
  logic             dvalid_r, dvalid_nxt;
  msg_desc_t        desc_r, desc_nxt;

  logic             accept;
  logic             first_item;
  logic [CNT_W-1:0] cnt_b;
  logic [SUM_W-1:0] fsum_b;
  logic [SUM_W-1:0] qsum_b;
  logic [SUM_W-1:0] term;
  logic [3:0]       ihl;
  logic [6:0]       qlim;
  logic             quote_ok;
  logic [CNT_W-1:0] qlen;
  logic [ACC_W-1:0] sum_a;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign busy       = (fstate_r != F_LOAD) || dvalid_r || !back_idle;
  assign accept     = start && !busy;
  assign first_item = !in_msg_r;
  assign cnt_b      = first_item ? '0 : cnt_r;
  assign fsum_b     = first_item ? '0 : fsum_r;
  assign qsum_b     = first_item ? '0 : qsum_r;
  assign term       = cnt_b[0] ? SUM_W'({8'd0, in_data_byte}) : SUM_W'({in_data_byte, 8'd0});

  assign ihl      = byte0_r[3:0];
  assign qlim     = {1'b0, ihl, 2'b00} + 7'(QUOTE_EXTRA);
  assign quote_ok = mode_r && (cnt_r >= CNT_W'(MIN_QUOTE_BYTES)) &&
                    (byte0_r[7:4] == IPV4_VERSION) && (ihl >= MIN_IHL) &&
                    (cnt_r >= CNT_W'({ihl, 2'b00}));
  assign qlen     = (quote_ok && (CNT_W'(qlim) < cnt_r)) ? CNT_W'(qlim) : cnt_r;
  assign sum_a    = ACC_W'(quote_ok ? qsum_r : fsum_r) + ACC_W'({type_r, code_r}) +
                    ACC_W'(rh_r) + ACC_W'(rl_r);
  assign fold1    = {1'b0, sum_a[15:0]} + 17'(sum_a[ACC_W-1:16]);
  assign fold2    = fold1[15:0] + 16'(fold1[16]);

  assign ram_waddr = cnt_b[ADDR_W-1:0];
  assign ram_wdata = in_data_byte;

  always_comb begin
    fstate_nxt = fstate_r;
    in_msg_nxt = in_msg_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    code_nxt   = code_r;
    rh_nxt     = rh_r;
    rl_nxt     = rl_r;
    mode_nxt   = mode_r;
    ovf_nxt    = ovf_r;
    byte0_nxt  = byte0_r;
    fsum_nxt   = fsum_r;
    qsum_nxt   = qsum_r;
    dvalid_nxt = dvalid_r && !desc_pop;
    desc_nxt   = desc_r;
    ram_we     = 1'b0;
    case (fstate_r)
      F_LOAD: begin
        if (accept) begin
          if (first_item) begin
            type_nxt = in_msg_type;
            code_nxt = in_error_mode ? in_msg_code : 8'd0;
            rh_nxt   = in_error_mode ? 16'd0 : in_rest_high;
            rl_nxt   = in_error_mode ? 16'd0 : in_rest_low;
            mode_nxt = in_error_mode;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            fsum_nxt = '0;
            qsum_nxt = '0;
          end
          if (in_byte_present) begin
            if (cnt_b < CNT_W'(MAX_PAYLOAD)) begin
              ram_we   = 1'b1;
              fsum_nxt = fsum_b + term;
              if ((cnt_b == '0) || (cnt_b < CNT_W'(qlim))) begin
                qsum_nxt = qsum_b + term;
              end
              if (cnt_b == '0) begin
                byte0_nxt = in_data_byte;
              end
              cnt_nxt = cnt_b + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          in_msg_nxt = !in_last_byte;
          if (in_last_byte) begin
            fstate_nxt = F_FINISH;
          end
        end
      end
      F_FINISH: begin
        desc_nxt.msg_type  = type_r;
        desc_nxt.msg_code  = code_r;
        desc_nxt.csum      = ~fold2;
        desc_nxt.rest_high = rh_r;
        desc_nxt.rest_low  = rl_r;
        desc_nxt.qlen      = qlen;
        desc_nxt.trunc     = ovf_r;
        dvalid_nxt         = 1'b1;
        fstate_nxt         = F_LOAD;
      end
      default: begin
        fstate_nxt = F_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_LOAD;
      in_msg_r <= 1'b0;
      cnt_r    <= '0;
      mode_r   <= 1'b0;
      ovf_r    <= 1'b0;
      dvalid_r <= 1'b0;
    end else begin
      fstate_r <= fstate_nxt;
      in_msg_r <= in_msg_nxt;
      cnt_r    <= cnt_nxt;
      mode_r   <= mode_nxt;
      ovf_r    <= ovf_nxt;
      dvalid_r <= dvalid_nxt;
    end
    type_r  <= type_nxt;
    code_r  <= code_nxt;
    rh_r    <= rh_nxt;
    rl_r    <= rl_nxt;
    byte0_r <= byte0_nxt;
    fsum_r  <= fsum_nxt;
    qsum_r  <= qsum_nxt;
    desc_r  <= desc_nxt;
  end

  assign desc_chan.valid = dvalid_r;
  assign desc_chan.desc  = desc_r;

endmodule

// ===== src/icmb_back.sv =====
// ----------------------------------------------------------------------------
// icmb_back
// Takes one message descriptor, walks the message byte by byte (header from
// the descriptor, payload from the byte store) and emits big-endian words.
// ----------------------------------------------------------------------------
module icmb_back #(
  parameter int ADDR_W = $clog2(icmb_pkg::MAX_PAYLOAD_DEF)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  icmb_pkg::desc_chan_t desc_chan,
  output logic                 desc_pop,
  output logic                 back_idle,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [7:0]           ram_rdata,
  output logic                 out_valid,
  output logic [31:0]          out_word,
  output logic [2:0]           out_bytes,
  output logic                 out_last,
  output logic                 out_truncated
);

  import icmb_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_CAPT} bstate_t;

  bstate_t          bstate_r, bstate_nxt;
  msg_desc_t        desc_r, desc_nxt;
  logic [POS_W-1:0] total_r, total_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      word_r, word_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r, out_word_nxt;
  logic [2:0]       out_bytes_r, out_bytes_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_trunc_r, out_trunc_nxt;

  logic [POS_W-1:0] pos_m8;
  logic [7:0]       hdr_byte;
  logic [7:0]       cur_byte;
  logic [1:0]       lane;
  logic [31:0]      word_cat;
  logic             end_msg;

  assign back_idle = (bstate_r == B_IDLE);
  assign desc_pop  = back_idle && desc_chan.valid;
  assign pos_m8    = pos_r - POS_W'(HDR_BYTES);
  assign ram_raddr = pos_m8[ADDR_W-1:0];
  assign lane      = pos_r[1:0];
  assign end_msg   = (pos_r == total_r - POS_W'(1));
  assign cur_byte  = (pos_r < POS_W'(HDR_BYTES)) ? hdr_byte : ram_rdata;

  always_comb begin
    case (pos_r[2:0])
      3'd0:    hdr_byte = desc_r.msg_type;
      3'd1:    hdr_byte = desc_r.msg_code;
      3'd2:    hdr_byte = desc_r.csum[15:8];
      3'd3:    hdr_byte = desc_r.csum[7:0];
      3'd4:    hdr_byte = desc_r.rest_high[15:8];
      3'd5:    hdr_byte = desc_r.rest_high[7:0];
      3'd6:    hdr_byte = desc_r.rest_low[15:8];
      default: hdr_byte = desc_r.rest_low[7:0];
    endcase
  end

  always_comb begin
    case (lane)
      2'd0:    word_cat = {cur_byte, 24'd0};
      2'd1:    word_cat = {word_r[31:24], cur_byte, 16'd0};
      2'd2:    word_cat = {word_r[31:16], cur_byte, 8'd0};
      default: word_cat = {word_r[31:8], cur_byte};
    endcase
  end

  always_comb begin
    bstate_nxt    = bstate_r;
    desc_nxt      = desc_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    case (bstate_r)
      B_IDLE: begin
        if (desc_chan.valid) begin
          desc_nxt   = desc_chan.desc;
          total_nxt  = POS_W'(HDR_BYTES) + POS_W'(desc_chan.desc.qlen);
          pos_nxt    = '0;
          bstate_nxt = B_READ;
        end
      end
      B_READ: begin
        bstate_nxt = B_CAPT;
      end
      B_CAPT: begin
        word_nxt = word_cat;
        if ((lane == 2'd3) || end_msg) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word_cat;
          out_bytes_nxt = {1'b0, lane} + 3'd1;
          out_last_nxt  = end_msg;
          out_trunc_nxt = desc_r.trunc;
        end
        if (end_msg) begin
          bstate_nxt = B_IDLE;
        end else begin
          pos_nxt    = pos_r + POS_W'(1);
          bstate_nxt = B_READ;
        end
      end
      default: begin
        bstate_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r    <= bstate_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r      <= desc_nxt;
    total_r     <= total_nxt;
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    out_word_r  <= out_word_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_bytes     = out_bytes_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

endmodule

// ===== src/icmp_message_builder_core.sv =====
// After the last item is accepted, the front part resolves the checksum and quote length,
// the back part takes the descriptor over, then each message byte (8 header bytes plus
// quoted payload) goes through B_READ and B_CAPT via the store read port into a word.
// Items are taken one per cycle while busy is low; words are never stalled by the receiver;
// busy stays high from the last item until the cycle of the last word.
// Reset (synchronous, rst_n low) clears control state; the byte store is not cleared.
// ----------------------------------------------------------------------------
// icmp_message_builder_core
// Builds ICMP messages with checksum from a byte stream and emits them as
// big-endian 32-bit words.
// ----------------------------------------------------------------------------
module icmp_message_builder_core #(
  parameter int MAX_PAYLOAD = icmb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_msg_type,
  input  logic [7:0]  in_msg_code,
  input  logic [15:0] in_rest_high,
  input  logic [15:0] in_rest_low,
  input  logic        in_error_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  output logic [31:0] out_word,
  output logic [2:0]  out_bytes,
  output logic        out_last,
  output logic        out_truncated
);

  import icmb_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PAYLOAD);

  desc_chan_t        desc_chan;
  logic              desc_pop;
  logic              back_idle;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  icmb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_msg_type     (in_msg_type),
    .in_msg_code     (in_msg_code),
    .in_rest_high    (in_rest_high),
    .in_rest_low     (in_rest_low),
    .in_error_mode   (in_error_mode),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .back_idle       (back_idle),
    .desc_pop        (desc_pop),
    .desc_chan       (desc_chan),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  icmb_ram #(
    .WIDTH  (8),
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  icmb_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc_chan     (desc_chan),
    .desc_pop      (desc_pop),
    .back_idle     (back_idle),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_word      (out_word),
    .out_bytes     (out_bytes),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

`ifndef SYNTHESIS
  a_last_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |=> busy)
    else $error("busy not raised after last item");

  a_last_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("word emitted right after last word");

  a_full_inner_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bytes == 3'd4)
    else $error("partial word before end of message");

  a_no_emit_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("word emitted while accepting items");
`endif

endmodule
